// ===== hw/rtl/cbmb_pkg.sv =====
// Shared types and codes for the clipped box mean blur block.
package cbmb_pkg;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_BOUNDS,
      ST_LAST,
      ST_BASE,
      ST_TEST,
      ST_READ,
      ST_TAIL,
      ST_DIV,
      ST_OUT
   } state_type;

   localparam logic [2:0] CSR_WIDTH  = 3'd0;
   localparam logic [2:0] CSR_HEIGHT = 3'd1;
   localparam logic [2:0] CSR_RAD_X  = 3'd2;
   localparam logic [2:0] CSR_RAD_Y  = 3'd3;

   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   localparam int CSR_DW = 9;

endpackage

// ===== hw/rtl/clipped_box_mean_blur_top.sv =====
// Top level of the clipped box mean blur: frame store, window sequencer, divider.
//
//  channel | ports                                   | direction
//  req     | req_valid req_ready req_op req_pixel_in | in
//  rsp     | rsp_valid rsp_ready rsp_blurred rsp_out_x rsp_out_y rsp_last_of_frame | out
//  csr     | csr_valid csr_ready csr_index csr_data  | in
//
// One transaction at a time. A pixel is written to the frame store on the
// accepting edge. Then the setup states ST_BOUNDS, ST_LAST, ST_BASE and ST_TEST
// decide whether the oldest output is ready; if so its clipped window is read
// one store entry per cycle through the single read port, then a restoring
// divider takes one quotient bit per cycle, then ST_OUT loads the output
// register. Without a ready output the transaction ends after ST_TEST.
// Reset clears counters and control; store contents are left undefined.
// A result waiting in the output register holds the next result in ST_OUT,
// and no new request is taken until that next result is loaded.
module clipped_box_mean_blur_top
   import cbmb_pkg::*;
#(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256,
   parameter int MAX_RADIUS = 15
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_op,
   input  logic [7:0]          req_pixel_in,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [7:0]          rsp_blurred,
   output logic [7:0]          rsp_out_x,
   output logic [7:0]          rsp_out_y,
   output logic                rsp_last_of_frame,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [2:0]          csr_index,
   input  logic [CSR_DW-1:0]   csr_data
);

   localparam int NPIX  = MAX_WIDTH * MAX_HEIGHT;
   localparam int XW    = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
   localparam int YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int WW    = $clog2(MAX_WIDTH + 1);
   localparam int HW    = $clog2(MAX_HEIGHT + 1);
   localparam int RW    = (MAX_RADIUS > 0) ? $clog2(MAX_RADIUS + 1) : 1;
   localparam int AW    = (NPIX > 1) ? $clog2(NPIX) : 1;
   localparam int CW    = $clog2(NPIX + 1);
   localparam int MXW   = (XW > YW) ? XW : YW;
   localparam int DW    = ((MXW > RW) ? MXW : RW) + 2;
   localparam int WIN   = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
   localparam int CNW   = $clog2(WIN + 1);
   localparam int SUMW  = $clog2(WIN * 256 + 1);
   localparam int DCW   = $clog2(SUMW + 1);

   // configuration registers, raw as written
   logic [8:0] width_ff, height_ff;
   logic [3:0] radx_ff, rady_ff;

   // effective (clamped) settings
   logic [WW-1:0] w_eff;
   logic [HW-1:0] h_eff;
   logic [RW-1:0] rx_eff, ry_eff;

   always_comb begin
      if (width_ff == 9'd0) w_eff = WW'(1);
      else if (32'(width_ff) > MAX_WIDTH) w_eff = WW'(MAX_WIDTH);
      else w_eff = WW'(width_ff);
      if (height_ff == 9'd0) h_eff = HW'(1);
      else if (32'(height_ff) > MAX_HEIGHT) h_eff = HW'(MAX_HEIGHT);
      else h_eff = HW'(height_ff);
      rx_eff = (32'(radx_ff) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(radx_ff);
      ry_eff = (32'(rady_ff) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(rady_ff);
   end

   state_type state_ff, state_in;

   logic [CW-1:0]  total_c;    // pixels per frame under the current settings
   logic [CW-1:0]  recv_ff;
   logic [XW-1:0]  ex_ff;      // column of the next output
   logic [YW-1:0]  ey_ff;      // row of the next output
   logic [XW-1:0]  x0_ff, x1_ff, ci_ff;
   logic [YW-1:0]  y0_ff, y1_ff, rj_ff;
   logic [CW-1:0]  last_idx_ff;
   logic [AW-1:0]  addr_ff, row_addr_ff;
   logic [CNW-1:0] cnt_ff;
   logic [SUMW-1:0] sum_ff;
   logic [SUMW-1:0] num_ff;    // dividend, becomes quotient
   logic [CNW:0]   rem_ff;
   logic [DCW-1:0] dstep_ff;
   logic           rd_vld_ff;
   logic [7:0]     mem_q_ff;

   logic           rsp_valid_ff, rsp_last_ff;
   logic [7:0]     rsp_blur_ff, rsp_x_ff, rsp_y_ff;

   logic [7:0] frame_mem [NPIX];

   logic req_acc, csr_acc, csr_hit, wr_en, rd_en, out_load;

   assign total_c   = CW'(w_eff) * CW'(h_eff);

   // a pending register write goes first, the request waits while it is offered
   assign req_ready = (state_ff == ST_IDLE) && !csr_valid;
   assign csr_ready = (state_ff == ST_IDLE);
   assign req_acc   = req_valid && req_ready;
   assign csr_acc   = csr_valid && csr_ready;
   assign csr_hit   = csr_acc && (csr_index == CSR_WIDTH || csr_index == CSR_HEIGHT ||
                                  csr_index == CSR_RAD_X || csr_index == CSR_RAD_Y);
   // pixels past the frame are discarded, behaving as drains
   assign wr_en     = req_acc && (req_op == OP_PIXEL) && (recv_ff < total_c);
   assign rd_en     = (state_ff == ST_READ);
   assign out_load  = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_ready);

   // window bounds, clipped to the image
   logic [DW-1:0] xs, ys, xlim, ylim;
   logic [XW-1:0] x0_c, x1_c;
   logic [YW-1:0] y0_c, y1_c;
   always_comb begin
      xs   = DW'(ex_ff) + DW'(rx_eff);
      ys   = DW'(ey_ff) + DW'(ry_eff);
      xlim = DW'(w_eff) - DW'(1);
      ylim = DW'(h_eff) - DW'(1);
      x0_c = (DW'(ex_ff) > DW'(rx_eff)) ? XW'(DW'(ex_ff) - DW'(rx_eff)) : '0;
      y0_c = (DW'(ey_ff) > DW'(ry_eff)) ? YW'(DW'(ey_ff) - DW'(ry_eff)) : '0;
      x1_c = (xs > xlim) ? XW'(xlim) : XW'(xs);
      y1_c = (ys > ylim) ? YW'(ylim) : YW'(ys);
   end

   logic [YW+WW-1:0] prod_last, prod_base;
   logic [2*DW-1:0]  prod_cnt;
   assign prod_last = y1_ff * w_eff;
   assign prod_base = y0_ff * w_eff;
   assign prod_cnt  = (DW'(x1_ff) - DW'(x0_ff) + DW'(1)) * (DW'(y1_ff) - DW'(y0_ff) + DW'(1));

   logic [CNW:0] trial;
   assign trial = {rem_ff[CNW-1:0], num_ff[SUMW-1]};

   logic last_pix;
   assign last_pix = (DW'(ex_ff) == xlim) && (DW'(ey_ff) == ylim);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_acc) state_in = ST_BOUNDS;
         ST_BOUNDS: state_in = ST_LAST;
         ST_LAST:   state_in = ST_BASE;
         ST_BASE:   state_in = ST_TEST;
         ST_TEST:   state_in = (last_idx_ff < recv_ff) ? ST_READ : ST_IDLE;
         ST_READ:   if (ci_ff == x1_ff && rj_ff == y1_ff) state_in = ST_TAIL;
         ST_TAIL:   if (!rd_vld_ff) state_in = ST_DIV;
         ST_DIV:    if (dstep_ff == DCW'(SUMW)) state_in = ST_OUT;
         ST_OUT:    if (out_load) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         width_ff     <= 9'd256;
         height_ff    <= 9'd256;
         radx_ff      <= 4'd1;
         rady_ff      <= 4'd1;
         recv_ff      <= '0;
         ex_ff        <= '0;
         ey_ff        <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rd_vld_ff <= rd_en;
         if (csr_acc) begin
            case (csr_index)
               CSR_WIDTH:  width_ff  <= csr_data;
               CSR_HEIGHT: height_ff <= csr_data;
               CSR_RAD_X:  radx_ff   <= csr_data[3:0];
               CSR_RAD_Y:  rady_ff   <= csr_data[3:0];
               default:    ;
            endcase
         end
         if (csr_hit) begin
            recv_ff <= '0;
            ex_ff   <= '0;
            ey_ff   <= '0;
         end else if (wr_en) begin
            recv_ff <= recv_ff + CW'(1);
         end else if (out_load) begin
            if (last_pix) begin
               recv_ff <= '0;
               ex_ff   <= '0;
               ey_ff   <= '0;
            end else if (DW'(ex_ff) == xlim) begin
               ex_ff <= '0;
               ey_ff <= ey_ff + YW'(1);
            end else begin
               ex_ff <= ex_ff + XW'(1);
            end
         end
         if (out_load) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   // datapath, no reset needed
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_BOUNDS: begin
            x0_ff <= x0_c;
            x1_ff <= x1_c;
            y0_ff <= y0_c;
            y1_ff <= y1_c;
         end
         ST_LAST: last_idx_ff <= CW'(prod_last) + CW'(x1_ff);
         ST_BASE: begin
            addr_ff     <= AW'(prod_base) + AW'(x0_ff);
            row_addr_ff <= AW'(prod_base) + AW'(x0_ff);
            ci_ff       <= x0_ff;
            rj_ff       <= y0_ff;
         end
         ST_TEST: begin
            cnt_ff <= CNW'(prod_cnt);
            sum_ff <= '0;
         end
         ST_READ: begin
            if (ci_ff == x1_ff) begin
               ci_ff       <= x0_ff;
               rj_ff       <= rj_ff + YW'(1);
               addr_ff     <= row_addr_ff + AW'(w_eff);
               row_addr_ff <= row_addr_ff + AW'(w_eff);
            end else begin
               ci_ff   <= ci_ff + XW'(1);
               addr_ff <= addr_ff + AW'(1);
            end
         end
         ST_TAIL: begin
            num_ff   <= sum_ff + SUMW'(cnt_ff >> 1);
            rem_ff   <= '0;
            dstep_ff <= '0;
         end
         ST_DIV: begin
            if (dstep_ff != DCW'(SUMW)) begin
               dstep_ff <= dstep_ff + DCW'(1);
               if (trial >= {1'b0, cnt_ff}) begin
                  rem_ff <= trial - {1'b0, cnt_ff};
                  num_ff <= {num_ff[SUMW-2:0], 1'b1};
               end else begin
                  rem_ff <= trial;
                  num_ff <= {num_ff[SUMW-2:0], 1'b0};
               end
            end
         end
         default: ;
      endcase
      if (rd_vld_ff) sum_ff <= sum_ff + SUMW'(mem_q_ff);
      if (out_load) begin
         rsp_blur_ff <= num_ff[7:0];
         rsp_x_ff    <= 8'(ex_ff);
         rsp_y_ff    <= 8'(ey_ff);
         rsp_last_ff <= last_pix;
      end
   end

   // frame store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) frame_mem[recv_ff[AW-1:0]] <= req_pixel_in;
      if (rd_en) mem_q_ff <= frame_mem[addr_ff];
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_blurred       = rsp_blur_ff;
   assign rsp_out_x         = rsp_x_ff;
   assign rsp_out_y         = rsp_y_ff;
   assign rsp_last_of_frame = rsp_last_ff;

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the clipped box mean blur block.
`timescale 1ns / 100ps

module testbench;
   import cbmb_pkg::*;

   typedef struct packed {
      logic [7:0] blurred;
      logic [7:0] out_x;
      logic [7:0] out_y;
      logic       last_of_frame;
   } blur_result_type;

   // ---------------------------------------------------------------
   // Clock, reset and block ports
   // ---------------------------------------------------------------
   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic              req_op = OP_PIXEL;
   logic [7:0]        req_pixel_in = 8'd0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [7:0]        rsp_blurred;
   logic [7:0]        rsp_out_x;
   logic [7:0]        rsp_out_y;
   logic              rsp_last_of_frame;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [2:0]        csr_index = CSR_WIDTH;
   logic [CSR_DW-1:0] csr_data = '0;

   always #10 clock = ~clock;

   clipped_box_mean_blur_top dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_op            (req_op),
      .req_pixel_in      (req_pixel_in),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_blurred       (rsp_blurred),
      .rsp_out_x         (rsp_out_x),
      .rsp_out_y         (rsp_out_y),
      .rsp_last_of_frame (rsp_last_of_frame),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   // ---------------------------------------------------------------
   // Predictor state: its own copy of the frame store, the counters
   // and the raw register values (clamping happens on use).
   // ---------------------------------------------------------------
   logic [7:0]   shadow_store [0:65535];
   int unsigned  px_received;
   int unsigned  px_emitted;
   logic [8:0]   reg_width;
   logic [8:0]   reg_height;
   logic [3:0]   reg_rad_x;
   logic [3:0]   reg_rad_y;

   blur_result_type pending_blur [$];

   int errors = 0;
   int items_sent = 0;
   int results_seen = 0;
   int frames_done = 0;
   int csr_writes = 0;

   // idle percentages per channel, and the long receiver hold-off
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_off_cycles = 0;

   function automatic int unsigned eff_dim(logic [8:0] v);
      if (v == 0) return 1;
      return (v > 256) ? 256 : v;
   endfunction

   function automatic int unsigned frame_pixels();
      return eff_dim(reg_width) * eff_dim(reg_height);
   endfunction

   // Records an accepted pixel, then the window mean of the oldest pending output, if its window is complete.
   function automatic void predict_blur(logic op, logic [7:0] px);
      int unsigned w, h, total, x, y, x0, x1, y0, y1, sum, cnt;
      blur_result_type r;
      w = eff_dim(reg_width);
      h = eff_dim(reg_height);
      total = w * h;
      if (op == OP_PIXEL && px_received < total) begin
         shadow_store[px_received] = px;
         px_received++;
      end
      if (px_emitted >= total) return;
      x = px_emitted % w;
      y = px_emitted / w;
      x0 = (x > reg_rad_x) ? x - reg_rad_x : 0;
      y0 = (y > reg_rad_y) ? y - reg_rad_y : 0;
      x1 = (x + reg_rad_x > w - 1) ? w - 1 : x + reg_rad_x;
      y1 = (y + reg_rad_y > h - 1) ? h - 1 : y + reg_rad_y;
      if (y1 * w + x1 >= px_received) return;
      sum = 0;
      cnt = 0;
      for (int j = y0; j <= y1; j++)
         for (int i = x0; i <= x1; i++) begin
            sum += shadow_store[j * w + i];
            cnt++;
         end
      r.blurred = 8'((sum + cnt / 2) / cnt);
      r.out_x = 8'(x);
      r.out_y = 8'(y);
      px_emitted++;
      r.last_of_frame = (px_emitted == total);
      if (r.last_of_frame) begin
         px_emitted = 0;
         px_received = 0;
      end
      pending_blur.push_back(r);
   endfunction

   // ---------------------------------------------------------------
   // Result checker: every accepted result against the oldest one due.
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      blur_result_type exp_r;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (pending_blur.size() == 0) begin
            errors++;
            $display("%0t: unexpected result blurred=%0d x=%0d y=%0d last=%0b", $time,
                     rsp_blurred, rsp_out_x, rsp_out_y, rsp_last_of_frame);
         end else begin
            exp_r = pending_blur.pop_front();
            if (exp_r.blurred !== rsp_blurred) begin
               errors++;
               $display("%0t: blurred expected %0d actual %0d", $time, exp_r.blurred,
                        rsp_blurred);
            end
            if (exp_r.out_x !== rsp_out_x) begin
               errors++;
               $display("%0t: out_x expected %0d actual %0d", $time, exp_r.out_x,
                        rsp_out_x);
            end
            if (exp_r.out_y !== rsp_out_y) begin
               errors++;
               $display("%0t: out_y expected %0d actual %0d", $time, exp_r.out_y,
                        rsp_out_y);
            end
            if (exp_r.last_of_frame !== rsp_last_of_frame) begin
               errors++;
               $display("%0t: last_of_frame expected %0b actual %0b", $time,
                        exp_r.last_of_frame, rsp_last_of_frame);
            end
         end
      end
   end

   // Receiver side: random stalls, or a long counted hold-off when asked.
   always @(negedge clock) begin
      if (hold_off_cycles > 0) begin
         rsp_ready <= 1'b0;
         hold_off_cycles <= hold_off_cycles - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // ---------------------------------------------------------------
   // Sender: one transaction on the request channel, predicted on accept.
   // Valid stays high into the next call when no gap is drawn.
   // ---------------------------------------------------------------
   task automatic send_item(logic op, logic [7:0] px);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_pixel_in <= px;
      do @(posedge clock); while (!req_ready);
      predict_blur(op, px);
      items_sent++;
   endtask

   // Waits until the block is idle, then writes one register.
   task automatic write_csr(logic [2:0] idx, logic [CSR_DW-1:0] value);
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_blur.size() != 0) @(posedge clock);
      // a no-result transaction may still be in its setup cycles
      repeat (50) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_WIDTH:  reg_width = value;
         CSR_HEIGHT: reg_height = value;
         CSR_RAD_X:  reg_rad_x = value[3:0];
         CSR_RAD_Y:  reg_rad_y = value[3:0];
         default: ;
      endcase
      // any register write restarts the frame
      px_received = 0;
      px_emitted = 0;
      csr_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_geometry(logic [8:0] w, logic [8:0] h, logic [3:0] rx,
                               logic [3:0] ry);
      write_csr(CSR_WIDTH, w);
      write_csr(CSR_HEIGHT, h);
      write_csr(CSR_RAD_X, rx);
      write_csr(CSR_RAD_Y, ry);
   endtask

   // Full frame of random pixels, random drains mixed in, then drains
   // (and the odd surplus pixel) until the predictor has closed the frame.
   task automatic run_frame(int drain_pct);
      int unsigned total;
      total = frame_pixels();
      for (int unsigned k = 0; k < total; k++) begin
         if ($urandom_range(99) < drain_pct) send_item(OP_DRAIN, 8'($urandom));
         send_item(OP_PIXEL, 8'($urandom));
      end
      while (px_received != 0)
         send_item(($urandom_range(9) == 0) ? OP_PIXEL : OP_DRAIN, 8'($urandom));
      frames_done++;
   endtask

   // ---------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------
   task automatic test_corner_frames();
      // single pixel, then a drain with nothing ready
      set_geometry(9'd1, 9'd1, 4'd0, 4'd0);
      send_item(OP_PIXEL, 8'd255);
      send_item(OP_DRAIN, 8'd0);
      // zero width counts as one column
      set_geometry(9'd0, 9'd3, 4'd1, 4'd1);
      send_item(OP_PIXEL, 8'd0);
      send_item(OP_PIXEL, 8'd255);
      send_item(OP_DRAIN, 8'd77);
      send_item(OP_PIXEL, 8'd128);
      send_item(OP_DRAIN, 8'd0);
      send_item(OP_DRAIN, 8'd0);
      frames_done++;
      // radius far beyond the image: every window clips to the whole frame
      set_geometry(9'd2, 9'd2, 4'd15, 4'd15);
      send_item(OP_PIXEL, 8'd255);
      send_item(OP_PIXEL, 8'd254);
      send_item(OP_PIXEL, 8'd1);
      send_item(OP_PIXEL, 8'd0);
      send_item(OP_PIXEL, 8'd170);   // past the frame: acts as a drain
      send_item(OP_PIXEL, 8'd85);
      send_item(OP_DRAIN, 8'd255);
      send_item(OP_DRAIN, 8'd0);
      frames_done++;
      // register write in the middle of a frame restarts it
      set_geometry(9'd2, 9'd2, 4'd0, 4'd0);
      send_item(OP_PIXEL, 8'd10);
      send_item(OP_PIXEL, 8'd20);
      write_csr(CSR_RAD_Y, 4'd1);
      run_frame(0);
   endtask

   task automatic test_geometry_extremes();
      // oversize width saturates to the widest row
      set_geometry(9'd511, 9'd1, 4'd15, 4'd0);
      run_frame(3);
      set_geometry(9'd1, 9'd300, 4'd0, 4'd15);
      run_frame(3);
      set_geometry(9'd256, 9'd1, 4'd0, 4'd15);
      run_frame(0);
   endtask

   task automatic test_backpressure();
      set_geometry(9'd6, 9'd5, 4'd1, 4'd2);
      @(negedge clock);
      hold_off_cycles = 600;
      run_frame(10);
   endtask

   task automatic test_random_frames(int target_items);
      int start_items;
      int phase_len;
      start_items = items_sent;
      phase_len = (target_items - start_items) / 3;
      while (items_sent < target_items) begin
         // idling: sender light/receiver heavy, then swapped, then none
         if (items_sent - start_items < phase_len) begin
            send_idle_pct = 24;
            recv_idle_pct = 55;
         end else if (items_sent - start_items < 2 * phase_len) begin
            send_idle_pct = 55;
            recv_idle_pct = 24;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         set_geometry(9'($urandom_range(12, 1)), 9'($urandom_range(10, 1)),
                      ($urandom_range(7) == 0) ? 4'd15 : 4'($urandom_range(3)),
                      ($urandom_range(7) == 0) ? 4'd15 : 4'($urandom_range(3)));
         run_frame($urandom_range(20));
      end
   endtask

   initial begin
      reg_width = 9'd256;
      reg_height = 9'd256;
      reg_rad_x = 4'd1;
      reg_rad_y = 4'd1;
      px_received = 0;
      px_emitted = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_corner_frames();
      test_geometry_extremes();
      test_backpressure();
      test_random_frames(1750);

      @(negedge clock);
      req_valid <= 1'b0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      while (pending_blur.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);

      $display("Covered %0d request transactions, %0d results, %0d frames,", items_sent,
               results_seen, frames_done);
      $display("%0d register writes, edge-clipped windows up to full radius.", csr_writes);
      if (errors == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #40_000_000;
      $display("timeout with %0d results still due", pending_blur.size());
      $display("testbench NOT OK");
      $finish;
   end

endmodule
